// ----- src/qgs_pkg.sv -----
// Shared types and widths for the gaze quaternion to screen pixel block.
// No dependencies; every other file imports this package.
package qgs_pkg;

  // Bit widths of the arithmetic path.
  localparam int unsigned CompW  = 16;
  localparam int unsigned DimW   = 14;
  localparam int unsigned PixW   = 15;
  localparam int unsigned DenW   = 36;
  localparam int unsigned NumW   = 52;
  localparam int unsigned QuoW   = 16;
  // The numerator is offset by the divisor shifted left by this many bits, so that it is never negative.
  localparam int unsigned OffSh  = 12;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMode   = 2'd2;

  // Products of the front end, handed to the divider.
  typedef struct packed {
    logic                     zero;
    logic signed [NumW:0]     mx;
    logic signed [NumW:0]     my;
    logic        [DenW-1:0]   den;
  } qgs_num_t;

endpackage

// ----- src/quaternion_gaze_to_screen_unit.sv -----
// Top level of the gaze quaternion to screen pixel block.
// Depends on qgs_pkg, qgs_front and qgs_div.
//
// Usage: an input item carries four signed Q1.14 quaternion components on
// comp_0_i..comp_3_i with a valid/ready handshake. Each item gives one result
// item with the floored screen coordinates pixel_x_o and pixel_y_o, or
// zero_norm_o set (coordinates 0) when all components are zero.
// Screen width, height and the y mapping mode are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i while no item is in flight.
// The item passes 22 register stages, the first loaded at the accepting edge:
// four front-end stages (products, norm, numerators, scaling), one offset
// stage, sixteen divider stages of one quotient bit each, and the output
// register. Throughput is one item per cycle while the output is not held.
// When the receiver holds out_ready_i low with a result waiting, the whole
// pipeline holds and in_ready_o drops; nothing is lost or repeated. Items
// keep entering while the output register is empty or being drained.
// Reset clears all valid bits and loads the default screen of 1920 by 1080
// with the inverted half-range y mapping.
module quaternion_gaze_to_screen_unit import qgs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [DimW-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [CompW-1:0] comp_0_i,
  input  logic signed [CompW-1:0] comp_1_i,
  input  logic signed [CompW-1:0] comp_2_i,
  input  logic signed [CompW-1:0] comp_3_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [PixW-1:0]  pixel_x_o,
  output logic signed [PixW-1:0]  pixel_y_o,
  output logic                    zero_norm_o
);

  logic [DimW-1:0] width_q, height_q;
  logic            mode_q;
  logic            en;
  logic            fv;
  qgs_num_t        num;
  logic [PixW-1:0] px, py;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(1920);
      height_q <= DimW'(1080);
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWidth:  width_q  <= cfg_wdata_i;
        RegHeight: height_q <= cfg_wdata_i;
        RegMode:   mode_q   <= cfg_wdata_i[0];
        default:   ;
      endcase
    end
  end

  // The pipeline advances whenever the output register is free or drains.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  qgs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .comp_0_i (comp_0_i),
    .comp_1_i (comp_1_i),
    .comp_2_i (comp_2_i),
    .comp_3_i (comp_3_i),
    .width_i  (width_q),
    .height_i (height_q),
    .mode_i   (mode_q),
    .valid_o  (fv),
    .num_o    (num)
  );

  qgs_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (fv),
    .num_i     (num),
    .valid_o   (out_valid_o),
    .pixel_x_o (px),
    .pixel_y_o (py),
    .zero_o    (zero_norm_o)
  );

  assign pixel_x_o = $signed(px);
  assign pixel_y_o = $signed(py);

endmodule

// ----- src/qgs_front.sv -----
// Front end: component products, norm, rotated vector and scaled numerators.
// Four register stages. Depends on qgs_pkg.
module qgs_front import qgs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [CompW-1:0] comp_0_i,
  input  logic signed [CompW-1:0] comp_1_i,
  input  logic signed [CompW-1:0] comp_2_i,
  input  logic signed [CompW-1:0] comp_3_i,
  input  logic [DimW-1:0]         width_i,
  input  logic [DimW-1:0]         height_i,
  input  logic                    mode_i,
  output logic                    valid_o,
  output qgs_num_t                num_o
);

  logic [3:0] v_q;

  logic signed [31:0] p00_q, p11_q, p22_q, p33_q, p01_q, p23_q, p13_q, p02_q;
  logic        [32:0] n2_q;
  logic signed [33:0] a_q, b_q;
  logic               z2_q, z3_q, z4_q;
  logic signed [37:0] sx_q, sy_q;
  logic        [DenW-1:0] d3_q, d4_q;
  logic signed [NumW:0] mx_q, my_q;

  logic        [32:0] n2_d;
  logic signed [32:0] s01, s13;
  logic signed [33:0] a_d, b_d;
  logic signed [37:0] n2s, as, bs, t7, sx_d, sy_d;
  logic        [36:0] d14;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  // Stage 2 and 3 arithmetic.
  always_comb begin
    n2_d = {1'b0, p00_q} + {1'b0, p11_q} + {1'b0, p22_q} + {1'b0, p33_q};
    s01  = {p01_q[31], p01_q} + {p23_q[31], p23_q};
    s13  = {p13_q[31], p13_q} - {p02_q[31], p02_q};
    a_d  = -({s01[32], s01} <<< 1);
    b_d  = {s13[32], s13} <<< 1;
    n2s  = $signed({5'b0, n2_q});
    as   = {{4{a_q[33]}}, a_q};
    bs   = {{4{b_q[33]}}, b_q};
    sx_d = (as <<< 3) + (as <<< 1) + (n2s <<< 3) - n2s;
    t7   = n2s - bs;
    if (mode_i) begin
      sy_d = (bs <<< 3) + (bs <<< 1) + (n2s <<< 3) - n2s;
    end else begin
      sy_d = (t7 <<< 3) - t7;
    end
    d14 = ({4'b0, n2_q} << 4) - ({4'b0, n2_q} << 1);
  end

  // Data stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= comp_0_i * comp_0_i;
      p11_q <= comp_1_i * comp_1_i;
      p22_q <= comp_2_i * comp_2_i;
      p33_q <= comp_3_i * comp_3_i;
      p01_q <= comp_0_i * comp_1_i;
      p23_q <= comp_2_i * comp_3_i;
      p13_q <= comp_1_i * comp_3_i;
      p02_q <= comp_0_i * comp_2_i;
      n2_q  <= n2_d;
      a_q   <= a_d;
      b_q   <= b_d;
      z2_q  <= (n2_d == '0);
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      d3_q  <= d14[DenW-1:0];
      z3_q  <= z2_q;
      mx_q  <= sx_q * $signed({1'b0, width_i});
      my_q  <= sy_q * $signed({1'b0, height_i});
      d4_q  <= d3_q;
      z4_q  <= z3_q;
    end
  end

  assign valid_o    = v_q[3];
  assign num_o.zero = z4_q;
  assign num_o.mx   = mx_q;
  assign num_o.my   = my_q;
  assign num_o.den  = d4_q;

endmodule

// ----- src/qgs_div.sv -----
// Pipelined restoring divider for both coordinates, one quotient bit a stage,
// followed by the output register. Depends on qgs_pkg.
module qgs_div import qgs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  qgs_num_t             num_i,
  output logic                 valid_o,
  output logic [PixW-1:0]      pixel_x_o,
  output logic [PixW-1:0]      pixel_y_o,
  output logic                 zero_o
);

  localparam int unsigned Stg = QuoW + 1;

  logic [Stg-1:0]  v_q;
  logic [NumW-1:0] rx_q [Stg];
  logic [NumW-1:0] ry_q [Stg];
  logic [QuoW-1:0] qx_q [Stg];
  logic [QuoW-1:0] qy_q [Stg];
  logic [DenW-1:0] d_q  [Stg];
  logic [Stg-1:0]  z_q;
  logic            vo_q, zo_q;
  logic [PixW-1:0] px_q, py_q;

  logic [NumW-1:0] rx_d [QuoW];
  logic [NumW-1:0] ry_d [QuoW];
  logic [QuoW-1:0] qx_d [QuoW];
  logic [QuoW-1:0] qy_d [QuoW];
  logic [NumW-1:0] ds   [QuoW];
  logic signed [NumW:0] offs, nx, ny;
  logic [QuoW-1:0] pxw, pyw;

  // Offset the numerators by a fixed multiple of the divisor, and work out
  // one quotient bit per stage.
  always_comb begin
    offs = $signed({{(NumW + 1 - DenW - OffSh){1'b0}}, num_i.den, {OffSh{1'b0}}});
    nx   = num_i.mx + offs;
    ny   = num_i.my + offs;
    for (int k = 0; k < QuoW; k++) begin
      ds[k]   = {{(NumW - DenW){1'b0}}, d_q[k]} << (QuoW - 1 - k);
      rx_d[k] = rx_q[k];
      ry_d[k] = ry_q[k];
      qx_d[k] = qx_q[k];
      qy_d[k] = qy_q[k];
      if (rx_q[k] >= ds[k]) begin
        rx_d[k] = rx_q[k] - ds[k];
        qx_d[k][QuoW - 1 - k] = 1'b1;
      end
      if (ry_q[k] >= ds[k]) begin
        ry_d[k] = ry_q[k] - ds[k];
        qy_d[k][QuoW - 1 - k] = 1'b1;
      end
    end
    pxw = qx_q[QuoW] - (QuoW'(1) << OffSh);
    pyw = qy_q[QuoW] - (QuoW'(1) << OffSh);
  end

  // Valid bits of the divider stages and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= {v_q[Stg-2:0], valid_i};
      vo_q <= v_q[Stg-1];
    end
  end

  // Data stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0] <= nx[NumW-1:0];
      ry_q[0] <= ny[NumW-1:0];
      qx_q[0] <= '0;
      qy_q[0] <= '0;
      d_q[0]  <= num_i.den;
      z_q[0]  <= num_i.zero;
      for (int k = 0; k < QuoW; k++) begin
        rx_q[k+1] <= rx_d[k];
        ry_q[k+1] <= ry_d[k];
        qx_q[k+1] <= qx_d[k];
        qy_q[k+1] <= qy_d[k];
        d_q[k+1]  <= d_q[k];
        z_q[k+1]  <= z_q[k];
      end
      zo_q <= z_q[QuoW];
      px_q <= z_q[QuoW] ? '0 : pxw[PixW-1:0];
      py_q <= z_q[QuoW] ? '0 : pyw[PixW-1:0];
    end
  end

  assign valid_o   = vo_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;
  assign zero_o    = zo_q;

endmodule

// ----- sim/quaternion_gaze_to_screen_unit_tb.sv -----
// Self-checking testbench for the gaze quaternion to screen pixel block.
// Depends on qgs_pkg and quaternion_gaze_to_screen_unit, and through it on qgs_front and qgs_div.
// Items run in phases of screen settings and idling, and each result is checked.
`timescale 1ns / 1ps

module quaternion_gaze_to_screen_unit_tb;
  import qgs_pkg::*;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned DrainWait = 40;

  typedef struct {
    logic signed [CompW-1:0] c0, c1, c2, c3;
  } quat_t;

  typedef struct {
    logic signed [PixW-1:0] px;
    logic signed [PixW-1:0] py;
    logic                   zero;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegWidth;
  logic [DimW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CompW-1:0] comp_0_i = '0, comp_1_i = '0, comp_2_i = '0, comp_3_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b1;
  logic signed [PixW-1:0] pixel_x_o, pixel_y_o;
  logic zero_norm_o;

  quaternion_gaze_to_screen_unit dut (.*);

  // Screen settings as the predictor sees them.
  logic [DimW-1:0] scr_w = 14'd1920;
  logic [DimW-1:0] scr_h = 14'd1080;
  logic            y_mode = 1'b0;

  quat_t  quat_queue[$];
  pixel_t pixel_queue[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_sender = 1'b0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Floor division for a positive divisor.
  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Rotates the forward vector by the quaternion and maps it onto the screen.
  function automatic pixel_t gaze_pixel(quat_t q);
    longint e0, e1, e2, e3, n2, a, b, px, py, w, h;
    pixel_t r;
    e0 = q.c0; e1 = q.c1; e2 = q.c2; e3 = q.c3;
    w = scr_w; h = scr_h;
    n2 = e0 * e0 + e1 * e1 + e2 * e2 + e3 * e3;
    r.px = '0; r.py = '0; r.zero = 1'b1;
    if (n2 != 0) begin
      a = -2 * (e0 * e1 + e2 * e3);
      b = 2 * (e1 * e3 - e0 * e2);
      px = floor_div((10 * a + 7 * n2) * w, 14 * n2);
      if (y_mode) py = floor_div((10 * b + 7 * n2) * h, 14 * n2);
      else py = floor_div((n2 - b) * h, 2 * n2);
      r.px = px[PixW-1:0];
      r.py = py[PixW-1:0];
      r.zero = 1'b0;
    end
    return r;
  endfunction

  // Driver: predicts each accepted item and presents the next one.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o)
      pixel_queue.push_back(gaze_pixel('{comp_0_i, comp_1_i, comp_2_i, comp_3_i}));
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && !hold_sender && quat_queue.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        quat_t q;
        q = quat_queue.pop_front();
        comp_0_i <= q.c0; comp_1_i <= q.c1; comp_2_i <= q.c2; comp_3_i <= q.c3;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (pixel_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item x=%0d y=%0d z=%0b",
                                       pixel_x_o, pixel_y_o, zero_norm_o);
      end else begin
        pixel_t e;
        e = pixel_queue.pop_front();
        if (e.px !== pixel_x_o || e.py !== pixel_y_o || e.zero !== zero_norm_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d z=%0b, got x=%0d y=%0d z=%0b",
                     e.px, e.py, e.zero, pixel_x_o, pixel_y_o, zero_norm_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("quaternion_gaze_to_screen_unit_tb: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [DimW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegWidth:  scr_w = data;
      RegHeight: scr_h = data;
      RegMode:   y_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (quat_queue.size() > 0 || in_valid_i || pixel_queue.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic signed [CompW-1:0] rand_comp(int unsigned kind);
    case (kind)
      0: return CompW'($urandom);
      1: return CompW'(int'($urandom_range(64)) - 32);
      default: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    int unsigned pick, kind;
    pick = $urandom_range(99);
    kind = (pick < 65) ? 0 : (pick < 85) ? 1 : 2;
    q.c0 = rand_comp(kind); q.c1 = rand_comp(kind);
    q.c2 = rand_comp(kind); q.c3 = rand_comp(kind);
    if (pick >= 97) q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
    else if (pick >= 92) begin
      // At most one non-zero component: the axis-aligned rotations.
      q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      case ($urandom_range(3))
        0: q.c0 = CompW'($urandom);
        1: q.c1 = CompW'($urandom);
        2: q.c2 = CompW'($urandom);
        default: q.c3 = CompW'($urandom);
      endcase
    end
    return q;
  endfunction

  task automatic run_phase(logic [DimW-1:0] w, logic [DimW-1:0] h, logic m,
                           int unsigned idle_mode, int unsigned count);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegMode, {13'd0, m});
    case (idle_mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 33; recv_stall_pct = 33; end
    endcase
    for (int i = 0; i < count; i++) quat_queue.push_back(rand_quat());
    drain();
  endtask

  // Stimulus sequence: directed items at reset settings, then phases of random items under set and random settings.
  initial begin
    int unsigned k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed items: zero norm, extremes of each component, identity-like, quarter turns.
    quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    quat_queue.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    quat_queue.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    quat_queue.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    quat_queue.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
    quat_queue.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    for (int i = 0; i < 4; i++) begin
      quat_t q;
      q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      case (i)
        0: q.c0 = 16'sh8000;
        1: q.c1 = 16'sh8000;
        2: q.c2 = 16'sh8000;
        default: q.c3 = 16'sh8000;
      endcase
      quat_queue.push_back(q);
      q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
      case (i)
        0: q.c0 = 16'sh7FFF;
        1: q.c1 = 16'sh7FFF;
        2: q.c2 = 16'sh7FFF;
        default: q.c3 = 16'sh7FFF;
      endcase
      quat_queue.push_back(q);
    end
    quat_queue.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd0});
    quat_queue.push_back('{16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
    quat_queue.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
    quat_queue.push_back('{16'sd11585, 16'sd0, 16'sd0, -16'sd11585});
    quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    drain();

    // An ignored register index must leave the settings alone.
    write_reg(2'd3, 14'h3FFF);

    run_phase(14'd1, 14'd1, 1'b1, 0, 150);
    run_phase(14'd8192, 14'd8192, 1'b0, 1, 150);
    run_phase(14'd8192, 14'd8192, 1'b1, 2, 150);
    run_phase(14'd0, 14'd0, 1'b0, 3, 100);
    run_phase(14'h3FFF, 14'h3FFF, 1'b1, 0, 120);
    run_phase(14'h3FFF, 14'h3FFF, 1'b0, 3, 120);

    // Sender holds off until every result is in, then resumes.
    for (int i = 0; i < 60; i++) quat_queue.push_back(rand_quat());
    repeat (20) @(posedge clk_i);
    hold_sender = 1'b1;
    while (in_valid_i || pixel_queue.size() > 0) @(posedge clk_i);
    hold_sender = 1'b0;
    drain();

    for (k = 0; k < 6; k++)
      run_phase(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                1'($urandom), k, 100);
    run_phase(14'd1920, 14'd1080, 1'b0, 2, 80);

    if (mismatches == 0 && pixel_queue.size() == 0) begin
      $display("quaternion_gaze_to_screen_unit_tb: clean");
    end else begin
      $display("quaternion_gaze_to_screen_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/qgs_pkg.sv
src/qgs_front.sv
src/qgs_div.sv
src/quaternion_gaze_to_screen_unit.sv
sim/quaternion_gaze_to_screen_unit_tb.sv
